### sv/binary_min_heap_queue_defines.svh
// ----------------------------------------------------------------------------
// binary_min_heap_queue_defines.svh
// Assertion macros shared by the heap queue RTL.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BMHQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BMHQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### sv/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Sizes, key type, codes and the key compare for the heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int CAPACITY      = 64;
    localparam int KEY_W         = 32;
    localparam int ADDR_W        = $clog2(CAPACITY);
    localparam int CNT_W         = $clog2(CAPACITY + 1);
    localparam int CHILD_W       = ADDR_W + 2;
    localparam int ENTRY_COUNT_W = 7;

    typedef logic signed [KEY_W-1:0] t_key;
    typedef logic [ADDR_W-1:0]       t_addr;
    typedef logic [CNT_W-1:0]        t_count;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    // signed strict less-than
    function automatic logic key_less(input t_key a, input t_key b);
        return a < b;
    endfunction

endpackage

### sv/bmhq_if.sv
// ----------------------------------------------------------------------------
// bmhq_if
// Request and response channels of the heap queue (valid/ready).
// ----------------------------------------------------------------------------
interface bmhq_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    bmhq_pkg::t_key     insert_value;

    modport source (output valid, output req_type, output insert_value, input ready);
    modport sink   (input valid, input req_type, input insert_value, output ready);
endinterface

interface bmhq_rsp_if;
    logic                                 valid;
    logic                                 ready;
    bmhq_pkg::t_key                       min_value;
    logic                                 queue_empty;
    logic [bmhq_pkg::ENTRY_COUNT_W-1:0]   entry_count;
    logic [1:0]                           status;

    modport source (output valid, output min_value, output queue_empty,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input min_value, input queue_empty,
                    input entry_count, input status, output ready);
endinterface

### sv/binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Min-heap priority queue of signed 32-bit keys with insert and remove-min.
// ----------------------------------------------------------------------------
// Each request transaction either inserts a key or removes the smallest one,
// and yields exactly one response transaction with the new minimum (zero when
// empty), the entry count, an empty flag and a status (done, insert rejected
// because full, remove rejected because empty). The keys live in a single
// memory with registered reads, and one sequencer walks the heap a level at a
// time: each level has a read step, which issues the read, and a compare
// step, which compares and writes back. An insert can climb
// log2(CAPACITY) = 6 levels and a remove descend at most 5. Every item
// ends in a step that loads the response register; rejected requests go
// straight from idle to that step. The request side is ready only while
// the sequencer is idle, so a new request is taken only once the sequencer
// has finished the previous one; a finished response waits in its output
// register while the next request is already taken, and the sequencer
// holds in its last step while the previous response has not been taken
// yet.
// No clearing pass is needed after reset: only slots below the count are used.
// ----------------------------------------------------------------------------
`include "binary_min_heap_queue_defines.svh"

module binary_min_heap_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bmhq_req_if.sink      i_req,
    bmhq_rsp_if.source    o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,    // insert: issue parent read, or finish at the root
        S_UP_CMP,   // insert: compare key with parent
        S_DN_LAST,  // remove: last entry read data arriving
        S_DN_RD,    // remove: issue both child reads, or finish at a leaf
        S_DN_CMP,   // remove: pick smaller child, compare with key
        S_DONE      // load the response register
    } t_state;

    t_state              r_state, n_state;
    bmhq_pkg::t_key      r_key, n_key;       // key being sifted
    bmhq_pkg::t_addr     r_pos, n_pos;       // hole position
    bmhq_pkg::t_count    r_count, n_count;
    bmhq_pkg::t_status   r_status, n_status;
    bmhq_pkg::t_key      r_root;             // mirror of slot 0

    // heap memory, one write port, two registered read ports
    bmhq_pkg::t_key      r_mem [bmhq_pkg::CAPACITY];
    bmhq_pkg::t_key      r_rd_a, r_rd_b;
    logic                wr_en;
    bmhq_pkg::t_addr     wr_addr, rd_addr_a, rd_addr_b;
    bmhq_pkg::t_key      wr_data;

    // response register
    logic                r_rsp_valid;
    bmhq_pkg::t_key      r_rsp_min;
    logic                r_rsp_empty;
    bmhq_pkg::t_count    r_rsp_count;
    bmhq_pkg::t_status   r_rsp_status;

    logic                req_fire;
    logic                rsp_free;
    bmhq_pkg::t_addr     parent;
    logic [bmhq_pkg::CHILD_W-1:0] left, right, count_ext;
    logic                right_ok;
    logic                pick_right;
    bmhq_pkg::t_key      pick_val;
    bmhq_pkg::t_addr     pick_pos;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign rsp_free    = !r_rsp_valid || o_rsp.ready;

    // heap index arithmetic
    assign parent    = bmhq_pkg::ADDR_W'((r_pos - 1'b1) >> 1);
    assign left      = bmhq_pkg::CHILD_W'({r_pos, 1'b1});
    assign right     = left + 1'b1;
    assign count_ext = bmhq_pkg::CHILD_W'(r_count);
    assign right_ok  = right < count_ext;

    // left wins ties
    assign pick_right = right_ok && bmhq_pkg::key_less(r_rd_b, r_rd_a);
    assign pick_val   = pick_right ? r_rd_b : r_rd_a;
    assign pick_pos   = pick_right ? right[bmhq_pkg::ADDR_W-1:0]
                                   : left[bmhq_pkg::ADDR_W-1:0];

    // sequencer next state and memory port control
    always_comb begin
        n_state   = r_state;
        n_key     = r_key;
        n_pos     = r_pos;
        n_count   = r_count;
        n_status  = r_status;
        wr_en     = 1'b0;
        wr_addr   = r_pos;
        wr_data   = r_key;
        rd_addr_a = left[bmhq_pkg::ADDR_W-1:0];
        rd_addr_b = right[bmhq_pkg::ADDR_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_status = bmhq_pkg::STATUS_DONE;
                    if (i_req.req_type == bmhq_pkg::REQ_INSERT) begin
                        if (r_count >= bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY)) begin
                            n_status = bmhq_pkg::STATUS_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_key   = i_req.insert_value;
                            n_pos   = bmhq_pkg::ADDR_W'(r_count);
                            n_count = r_count + 1'b1;
                            n_state = S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = bmhq_pkg::STATUS_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            // fetch the last entry; it moves to the root
                            rd_addr_a = bmhq_pkg::ADDR_W'(r_count - 1'b1);
                            n_count   = r_count - 1'b1;
                            n_state   = S_DN_LAST;
                        end
                    end
                end
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    wr_en   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    rd_addr_a = parent;
                    n_state   = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                wr_en = 1'b1;
                if (bmhq_pkg::key_less(r_key, r_rd_a)) begin
                    // parent moves down into the hole
                    wr_data = r_rd_a;
                    n_pos   = parent;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DN_LAST: begin
                n_key   = r_rd_a;
                n_pos   = '0;
                n_state = S_DN_RD;
            end
            S_DN_RD: begin
                if (left >= count_ext) begin
                    wr_en   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                wr_en = 1'b1;
                if (bmhq_pkg::key_less(pick_val, r_key)) begin
                    // smaller child moves up into the hole
                    wr_data = pick_val;
                    n_pos   = pick_pos;
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (rsp_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // heap memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_status    <= bmhq_pkg::STATUS_DONE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_status <= n_status;
            if (r_state == S_DONE && rsp_free) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
        // payload, no reset
        r_key <= n_key;
        r_pos <= n_pos;
        if (wr_en && wr_addr == '0) begin
            r_root <= wr_data;
        end
        if (r_state == S_DONE && rsp_free) begin
            r_rsp_min    <= (r_count == '0) ? '0 : r_root;
            r_rsp_empty  <= (r_count == '0);
            r_rsp_count  <= r_count;
            r_rsp_status <= r_status;
        end
    end

    assign o_rsp.valid       = r_rsp_valid;
    assign o_rsp.min_value   = r_rsp_min;
    assign o_rsp.queue_empty = r_rsp_empty;
    assign o_rsp.entry_count = bmhq_pkg::ENTRY_COUNT_W'(r_rsp_count);
    assign o_rsp.status      = r_rsp_status;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `BMHQ_ASSERT_NOW(a_count_max, 1'b1,
        r_count <= bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY), "count above capacity")
    `BMHQ_ASSERT_NEXT(a_insert_count,
        req_fire && i_req.req_type == bmhq_pkg::REQ_INSERT &&
        r_count < bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY),
        r_count == $past(r_count) + 1'b1, "accepted insert did not grow count")
    `BMHQ_ASSERT_NOW(a_hole_in_range,
        r_state == S_UP_RD || r_state == S_UP_CMP,
        bmhq_pkg::CNT_W'(r_pos) < r_count, "sift position outside heap")
    `BMHQ_ASSERT_NOW(a_empty_flag, r_rsp_valid,
        r_rsp_empty == (r_rsp_count == '0), "empty flag disagrees with count")
    `BMHQ_ASSERT_NOW(a_empty_min, r_rsp_valid && r_rsp_empty,
        r_rsp_min == '0, "empty response with nonzero minimum")

endmodule
